[sv/spce_pkg.sv]
// shared types and the variable-length code table for the static prefix code encoder
package spce_pkg;

  typedef struct packed {
    logic [8:0] bits;
    logic [3:0] len;
  } spce_code_t;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } spce_res_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  function automatic spce_code_t spce_lookup(input logic [7:0] ch);
    spce_code_t c;
    case (ch)
      8'h61:      c = '{9'h00E, 4'd4};
      8'h62:      c = '{9'h047, 4'd7};
      8'h63:      c = '{9'h017, 4'd5};
      8'h64:      c = '{9'h087, 4'd8};
      8'h65:      c = '{9'h009, 4'd4};
      8'h66:      c = '{9'h044, 4'd7};
      8'h67:      c = '{9'h046, 4'd7};
      8'h68:      c = '{9'h045, 4'd7};
      8'h69:      c = '{9'h00C, 4'd4};
      8'h6A:      c = '{9'h03E, 4'd6};
      8'h6B:      c = '{9'h003, 4'd5};
      8'h6C:      c = '{9'h041, 4'd7};
      8'h6D:      c = '{9'h040, 4'd7};
      8'h6E:      c = '{9'h005, 4'd4};
      8'h6F:      c = '{9'h00A, 4'd4};
      8'h70:      c = '{9'h002, 4'd5};
      8'h71:      c = '{9'h109, 4'd9};
      8'h72:      c = '{9'h004, 4'd4};
      8'h73:      c = '{9'h01B, 4'd5};
      8'h74:      c = '{9'h01A, 4'd5};
      8'h75:      c = '{9'h03F, 4'd6};
      8'h76:      c = '{9'h108, 4'd9};
      8'h77:      c = '{9'h01E, 4'd5};
      8'h78:      c = '{9'h085, 4'd8};
      8'h79:      c = '{9'h016, 4'd5};
      8'h7A:      c = '{9'h002, 4'd4};
      CH_SPACE:   c = '{9'h007, 4'd4};
      CH_PERIOD:  c = '{9'h006, 4'd4};
      CH_NEWLINE: c = '{9'h003, 4'd4};
      default:    c = '{9'h000, 4'd3};
    endcase
    return c;
  endfunction

endpackage

[sv/static_prefix_code_encoder_unit.sv]
// static prefix code encoder top level
// output: a byte appears on the output in the cycle after its request is accepted
// throughput: one request per cycle while each makes at most one byte and out_tready is high; a request
// that completes two bytes holds the input until its first byte is taken (two-entry output register)
// reset: synchronous active-low rst_n clears the bit accumulator and the output register level
module static_prefix_code_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // symbol
  input  logic       in_tuser,   // command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast
);
  import spce_pkg::*;

  spce_res_t  res;
  logic       accept;
  logic [1:0] level;

  assign in_tready = (level == 2'd0) || ((level == 2'd1) && out_tready);
  assign accept    = in_tvalid && in_tready;

  spce_encode u_encode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .command (in_tuser),
    .symbol  (in_tdata),
    .res     (res)
  );

  spce_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .level      (level)
  );

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level != 2'd3) else $error("output register level out of range");

  a_flush_one: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == CMD_FLUSH) |-> (res.n != 2'd2))
    else $error("flush produced two bytes");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.n != 2'd0) |=> out_tvalid)
    else $error("result not presented after request");

  a_two_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.n == 2'd2) |=> (level == 2'd2 && !out_tlast))
    else $error("two-byte result not queued in order");

endmodule

[sv/spce_encode.sv]
// code lookup, bit accumulator and byte extraction for one request
module spce_encode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               command,
  input  logic [7:0]         symbol,
  output spce_pkg::spce_res_t res
);
  import spce_pkg::*;

  logic [6:0]  acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  spce_code_t  code;
  logic [15:0] acc_sh;
  logic [4:0]  total;
  logic [4:0]  rem;
  logic [7:0]  mask;
  logic [7:0]  flush_b;

  always_comb begin
    code    = spce_lookup(symbol);
    acc_sh  = ({9'd0, acc_r} << code.len) | {7'd0, code.bits};
    total   = {2'b00, cnt_r} + {1'b0, code.len};
    flush_b = 8'({1'b0, acc_r} << (4'd8 - {1'b0, cnt_r}));
    res.b0  = 8'd0;
    res.b1  = 8'd0;
    res.n   = 2'd0;
    rem     = total;
    if (total >= 5'd16) begin
      res.n  = 2'd2;
      res.b0 = acc_sh[15:8];
      res.b1 = acc_sh[7:0];
      rem    = 5'd0;
    end else if (total >= 5'd8) begin
      res.n  = 2'd1;
      rem    = total - 5'd8;
      res.b0 = 8'(acc_sh >> rem);
    end
    mask    = (8'd1 << rem[2:0]) - 8'd1;
    acc_nxt = acc_sh[6:0] & mask[6:0];
    cnt_nxt = rem[2:0];
    if (command == CMD_FLUSH) begin
      res.n   = (cnt_r != 3'd0) ? 2'd1 : 2'd0;
      res.b0  = flush_b;
      res.b1  = 8'd0;
      acc_nxt = 7'd0;
      cnt_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 7'd0;
      cnt_r <= 3'd0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/spce_outq.sv]
// two-entry result register feeding the output stream
module spce_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spce_pkg::spce_res_t res,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [1:0]          level
);
  import spce_pkg::*;

  logic [8:0] q0_r, q0_nxt;
  logic [8:0] q1_r, q1_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (lvl_r != 2'd0);
  assign out_tdata  = q0_r[7:0];
  assign out_tlast  = q0_r[8];
  assign level      = lvl_r;

  // a request is only taken when the register is empty after this cycle's pop
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    lvl_nxt = lvl_r;
    if (pop) begin
      q0_nxt  = q1_r;
      lvl_nxt = lvl_r - 2'd1;
    end
    if (push) begin
      q0_nxt  = {res.n == 2'd1, res.b0};
      q1_nxt  = {1'b1, res.b1};
      lvl_nxt = res.n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= 2'd0;
    end else begin
      lvl_r <= lvl_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule
